/* hw/rtl/size_string_suffix_parser_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the size string suffix parser
// Concurrent checks on the rising clock edge, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef SIZE_STRING_SUFFIX_PARSER_ASSERT_SVH
`define SIZE_STRING_SUFFIX_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge while reset is low.
`define SSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SSP_ASSERT(label, prop, msg)
`define SSP_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* hw/rtl/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// Size string suffix parser package
// Status codes, pipeline stage record and fixed sizes.
// ----------------------------------------------------------------------------
package ssp_pkg;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_NO_DIGITS       = 3'd1,
    ST_UNKNOWN_SUFFIX  = 3'd2,
    ST_SUFFIX_TOO_LONG = 3'd3,
    ST_OVERFLOW        = 3'd4
  } status_t;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned POW_W   = 3;
  localparam int unsigned STAGES  = 4;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POW_W-1:0]   pow_left;
    logic               use_1000;
    status_t            status;
  } stage_t;

endpackage

/* hw/rtl/ssp_in_if.sv */
// ----------------------------------------------------------------------------
// Character channel
// One character or the end-of-string marker per beat.
// ----------------------------------------------------------------------------
interface ssp_in_if;
  logic                       valid;
  logic                       ready;
  logic [ssp_pkg::CHAR_W-1:0] char_code;
  logic                       end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink (input valid, input char_code, input end_of_string, output ready);
endinterface

/* hw/rtl/ssp_out_if.sv */
// ----------------------------------------------------------------------------
// Size result channel
// One parsed size and its status per beat.
// ----------------------------------------------------------------------------
interface ssp_out_if;
  logic                        valid;
  logic                        ready;
  logic [ssp_pkg::VALUE_W-1:0] size_value;
  logic [2:0]                  status;

  modport source (output valid, output size_value, output status, input ready);
  modport sink (input valid, input size_value, input status, output ready);
endinterface

/* hw/rtl/size_string_suffix_parser.sv */
// ----------------------------------------------------------------------------
// Size string suffix parser
// Parses a decimal size with an optional k/m/g/t or kb/mb/gb/tb suffix.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat
// chars    in   char_code[7:0], end_of_string
// sizes    out  size_value[63:0], status[2:0]
//
// One character beat is taken per cycle; digits update the accumulator at once.
// An end beat enters a five-register result pipeline: decode, then four scaling
// stages of at most one times-1000 or times-1024 step each. Stages advance
// independently and hold when the output stalls; chars.ready drops only when
// the whole pipeline is full. Reset is synchronous and clears the parse state
// and all stage valid bits.
// ----------------------------------------------------------------------------
`include "size_string_suffix_parser_assert.svh"

module size_string_suffix_parser #(
  parameter int unsigned MAX_DIGITS = 20
) (
  input logic      clk,
  input logic      rst,
  ssp_in_if.sink   chars,
  ssp_out_if.source sizes
);

  localparam int unsigned DC_W   = $clog2(MAX_DIGITS + 1);
  localparam logic [DC_W-1:0] DC_MAX = DC_W'(MAX_DIGITS);
  localparam int unsigned NS     = ssp_pkg::STAGES;
  localparam int unsigned VW     = ssp_pkg::VALUE_W;
  localparam int unsigned CW     = ssp_pkg::CHAR_W;
  localparam int unsigned PW     = ssp_pkg::POW_W;
  localparam int unsigned PROD_W = VW + 10;

  localparam logic [CW-1:0] CH_0 = 8'h30;
  localparam logic [CW-1:0] CH_9 = 8'h39;
  localparam logic [CW-1:0] CH_UA = 8'h41;
  localparam logic [CW-1:0] CH_UZ = 8'h5a;
  localparam logic [CW-1:0] CH_K = 8'h6b;
  localparam logic [CW-1:0] CH_M = 8'h6d;
  localparam logic [CW-1:0] CH_G = 8'h67;
  localparam logic [CW-1:0] CH_T = 8'h74;
  localparam logic [CW-1:0] CH_B = 8'h62;

  function automatic logic [CW-1:0] lower_ascii(logic [CW-1:0] c);
    logic [CW-1:0] r;
    r = c;
    if (c >= CH_UA && c <= CH_UZ) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [PW-1:0] unit_power(logic [CW-1:0] c);
    logic [PW-1:0] p;
    case (lower_ascii(c))
      CH_K: p = 3'd1;
      CH_M: p = 3'd2;
      CH_G: p = 3'd3;
      CH_T: p = 3'd4;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic ssp_pkg::stage_t scale_step(ssp_pkg::stage_t s);
    ssp_pkg::stage_t     r;
    logic [PROD_W-1:0]   ext;
    logic [PROD_W-1:0]   prod;
    r    = s;
    ext  = {10'd0, s.value};
    prod = s.use_1000 ? (ext << 10) - (ext << 4) - (ext << 3) : (ext << 10);
    if (s.pow_left != '0) begin
      r.value    = prod[VW-1:0];
      r.pow_left = s.pow_left - 3'd1;
      if (prod[PROD_W-1:VW] != '0 && s.status == ssp_pkg::ST_OK) begin
        r.status = ssp_pkg::ST_OVERFLOW;
      end
    end
    if (r.status != ssp_pkg::ST_OK) begin
      r.value = '0;
    end
    return r;
  endfunction

  logic [VW-1:0]   number_accum;
  logic [DC_W-1:0] digit_count;
  logic            in_suffix_phase;
  logic [1:0]      suffix_length;
  logic [CW-1:0]   suffix_first_char;
  logic [CW-1:0]   suffix_second_char;

  ssp_pkg::stage_t st [NS+1];
  logic [NS:0]     vld;
  logic [NS:0]     rdy;

  logic            take;
  logic            is_digit;
  logic            take_digit;
  logic [VW+3:0]   acc_x10;
  logic [VW-1:0]   accum_next;
  logic [PW-1:0]   first_pow;
  logic            second_is_b;
  ssp_pkg::stage_t head_next;

  always_comb begin
    rdy[NS] = !vld[NS] || sizes.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign chars.ready = rdy[0];
  assign take        = chars.valid && rdy[0];

  assign is_digit   = chars.char_code >= CH_0 && chars.char_code <= CH_9;
  assign take_digit = !in_suffix_phase && is_digit && digit_count < DC_MAX;
  assign acc_x10    = ({4'd0, number_accum} << 3) + ({4'd0, number_accum} << 1)
                    + {{(VW + 4 - CW){1'b0}}, chars.char_code - CH_0};
  assign accum_next = (acc_x10[VW+3:VW] != '0) ? '1 : acc_x10[VW-1:0];

  assign first_pow   = unit_power(suffix_first_char);
  assign second_is_b = lower_ascii(suffix_second_char) == CH_B;

  always_comb begin
    head_next.value    = number_accum;
    head_next.pow_left = '0;
    head_next.use_1000 = suffix_length == 2'd2;
    head_next.status   = ssp_pkg::ST_OK;
    if (digit_count == '0) begin
      head_next.status = ssp_pkg::ST_NO_DIGITS;
    end else if (suffix_length == 2'd3) begin
      head_next.status = ssp_pkg::ST_SUFFIX_TOO_LONG;
    end else if (suffix_length == 2'd1) begin
      if (first_pow == '0) begin
        head_next.status = ssp_pkg::ST_UNKNOWN_SUFFIX;
      end else begin
        head_next.pow_left = first_pow;
      end
    end else if (suffix_length == 2'd2) begin
      if (first_pow == '0 || !second_is_b) begin
        head_next.status = ssp_pkg::ST_UNKNOWN_SUFFIX;
      end else begin
        head_next.pow_left = first_pow;
      end
    end
    if (head_next.status != ssp_pkg::ST_OK) begin
      head_next.value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_accum       <= '0;
      digit_count        <= '0;
      in_suffix_phase    <= 1'b0;
      suffix_length      <= '0;
      suffix_first_char  <= '0;
      suffix_second_char <= '0;
    end else if (take) begin
      if (chars.end_of_string) begin
        number_accum       <= '0;
        digit_count        <= '0;
        in_suffix_phase    <= 1'b0;
        suffix_length      <= '0;
        suffix_first_char  <= '0;
        suffix_second_char <= '0;
      end else if (take_digit) begin
        number_accum <= accum_next;
        digit_count  <= digit_count + 1'b1;
      end else begin
        in_suffix_phase <= 1'b1;
        if (suffix_length == 2'd0) begin
          suffix_first_char <= chars.char_code;
        end
        if (suffix_length == 2'd1) begin
          suffix_second_char <= chars.char_code;
        end
        if (suffix_length != 2'd3) begin
          suffix_length <= suffix_length + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= chars.valid && chars.end_of_string;
      end
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st[0] <= head_next;
    end
    for (int k = 1; k <= NS; k++) begin
      if (rdy[k]) begin
        st[k] <= scale_step(st[k-1]);
      end
    end
  end

  assign sizes.valid      = vld[NS];
  assign sizes.size_value = st[NS].value;
  assign sizes.status     = st[NS].status;

  `SSP_ASSERT(a_error_value_zero, sizes.valid && sizes.status != ssp_pkg::ST_OK |-> sizes.size_value == '0, "error result carries a nonzero size")
  `SSP_ASSERT(a_clear_after_end, take && chars.end_of_string |=> digit_count == '0 && suffix_length == '0 && !in_suffix_phase, "parse state not cleared after end beat")
  `SSP_ASSERT(a_digit_bound, digit_count <= DC_MAX, "digit count beyond its limit")
  `SSP_ASSERT_ALWAYS(a_reset_empty, rst |=> !sizes.valid && vld == '0, "result pipeline not empty after reset")

endmodule
